// File: rtl/bbmq_pkg.sv
// shared types and codes for the bip buffer message queue
`default_nettype none
package bbmq_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int HEADER_BYTES_DEF = 2;
    localparam int LEN_W            = 12;
    localparam int BYTE_W           = 8;

    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_FILL = 2'd1;
    localparam logic [1:0] REQ_POP  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [LEN_W-1:0]  msg_length;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              first_of_message;
        logic              last_of_message;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_FILL,
        OP_POP,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/bbmq_front.sv
// request intake: decodes each request and queues it for the back end
`default_nettype none
module bbmq_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire bbmq_pkg::t_in_item i_in,
    output logic                    o_in_stall,
    output logic                    o_cmd_valid,
    output bbmq_pkg::t_cmd          o_cmd,
    input  wire logic               i_cmd_deq
);
    import bbmq_pkg::*;

    t_cmd       r_q [2];
    logic       r_wrp;
    logic       r_rdp;
    logic [1:0] r_cnt;
    t_cmd       cmd_in;
    logic       push;
    logic       pop;

    always_comb begin
        cmd_in.len  = i_in.msg_length;
        cmd_in.data = i_in.data_byte;
        unique case (i_in.req_type)
            REQ_SEND: cmd_in.op = OP_SEND;
            REQ_FILL: cmd_in.op = OP_FILL;
            REQ_POP:  cmd_in.op = OP_POP;
            default:  cmd_in.op = OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rdp];
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_deq && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wrp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrp <= 1'b0;
            r_rdp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wrp <= !r_wrp;
            end
            if (pop) begin
                r_rdp <= !r_rdp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// File: rtl/bbmq_back.sv
// execution end: region pointers, byte store and result register
`default_nettype none
module bbmq_back #(
    parameter int BUFFER_BYTES = bbmq_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES = bbmq_pkg::HEADER_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire bbmq_pkg::t_cmd   i_cmd,
    output logic                  o_cmd_deq,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output bbmq_pkg::t_out_item   o_out
);
    import bbmq_pkg::*;

    localparam int PW  = $clog2(BUFFER_BYTES + 1);
    localparam int AW  = $clog2(BUFFER_BYTES);
    localparam int CW  = (PW > 13) ? PW : 13;
    localparam int HCW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int HDR_LIMIT = (HEADER_BYTES * 8 < LEN_W) ? (1 << (8 * HEADER_BYTES)) - 1
                                                          : (1 << LEN_W) - 1;
    localparam logic [CW-1:0]    BUF_C    = CW'(BUFFER_BYTES);
    localparam logic [CW-1:0]    HDR_C    = CW'(HEADER_BYTES);
    localparam logic [PW-1:0]    HDR_P    = PW'(HEADER_BYTES);
    localparam logic [LEN_W-1:0] LIMIT_L  = LEN_W'(HDR_LIMIT);
    localparam logic [HCW-1:0]   HCNT_END = HCW'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_H0,
        S_H1,
        S_HD,
        S_PL
    } t_state;

    logic [BYTE_W-1:0] r_mem [BUFFER_BYTES];
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] r_rd_data;

    t_state           r_state,  n_state;
    logic [PW-1:0]    r_rp,     n_rp;
    logic [PW-1:0]    r_pe,     n_pe;
    logic [PW-1:0]    r_se,     n_se;
    logic [PW-1:0]    r_fp,     n_fp;
    logic [LEN_W-1:0] r_btf,    n_btf;
    logic [LEN_W-1:0] r_btp,    n_btp;
    logic             r_inside, n_inside;
    logic [LEN_W-1:0] r_mlen,   n_mlen;
    logic             r_first,  n_first;
    logic [HCW-1:0]   r_hcnt,   n_hcnt;
    logic [LEN_W-1:0] r_hlen,   n_hlen;
    logic [PW-1:0]    r_haddr,  n_haddr;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out,    n_out;

    logic             can_out;
    logic [CW-1:0]    total;
    logic             fits_pri;
    logic             fits_sec;
    logic [PW-1:0]    rp_h;
    logic [PW-1:0]    rp_p1;
    logic [PW-1:0]    haddr_i;
    logic [LEN_W-1:0] btp_new;
    logic [BYTE_W-1:0] hbyte;

    function automatic logic [PW-1:0] rp_fp_inc(input logic [PW-1:0] p);
        rp_fp_inc = p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign can_out  = !r_out_valid || !i_out_stall;
    assign total    = HDR_C + CW'(i_cmd.len);
    assign fits_pri = (BUF_C - CW'(r_pe)) >= total;
    assign fits_sec = (r_rp >= r_se) && ((CW'(r_rp) - CW'(r_se)) >= total);
    assign rp_h     = r_rp + HDR_P;
    assign rp_p1    = r_rp + PW'(1);
    assign haddr_i  = r_haddr + {{(PW-HCW){1'b0}}, r_hcnt};
    assign btp_new  = (r_first ? r_mlen : r_btp) - LEN_W'(1);

    always_comb begin
        if (r_hcnt == HCW'(0)) begin
            hbyte = r_hlen[7:0];
        end else if (r_hcnt == HCW'(1)) begin
            hbyte = {4'd0, r_hlen[LEN_W-1:8]};
        end else begin
            hbyte = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_pe        = r_pe;
        n_se        = r_se;
        n_fp        = r_fp;
        n_btf       = r_btf;
        n_btp       = r_btp;
        n_inside    = r_inside;
        n_mlen      = r_mlen;
        n_first     = r_first;
        n_hcnt      = r_hcnt;
        n_hlen      = r_hlen;
        n_haddr     = r_haddr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_cmd_deq   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = AW'(r_fp);
        wr_data     = i_cmd.data;
        rd_en       = 1'b0;
        rd_addr     = AW'(r_rp);

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && can_out) begin
                    o_cmd_deq = 1'b1;
                    n_out     = '0;
                    unique case (i_cmd.op)
                        OP_SEND: begin
                            n_out_valid = 1'b1;
                            if (r_btf != '0) begin
                                n_out.status = ST_BUSY;
                            end else if (i_cmd.len > LIMIT_L) begin
                                n_out.status = ST_NO_ROOM;
                            end else if ((r_se == '0) && fits_pri) begin
                                n_haddr = r_pe;
                                n_pe    = PW'(CW'(r_pe) + total);
                                n_fp    = r_pe + HDR_P;
                                n_btf   = i_cmd.len;
                                n_hlen  = i_cmd.len;
                                n_hcnt  = '0;
                                n_state = S_HDR;
                            end else if (fits_sec) begin
                                n_haddr = r_se;
                                n_se    = PW'(CW'(r_se) + total);
                                n_fp    = r_se + HDR_P;
                                n_btf   = i_cmd.len;
                                n_hlen  = i_cmd.len;
                                n_hcnt  = '0;
                                n_state = S_HDR;
                            end else begin
                                n_out.status = ST_NO_ROOM;
                            end
                        end
                        OP_FILL: begin
                            n_out_valid = 1'b1;
                            if (r_btf == '0) begin
                                n_out.status = ST_BUSY;
                            end else begin
                                wr_en = 1'b1;
                                n_fp  = rp_fp_inc(r_fp);
                                n_btf = r_btf - LEN_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_btf != '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_BUSY;
                            end else if (r_inside) begin
                                rd_en   = 1'b1;
                                n_first = 1'b0;
                                n_state = S_PL;
                            end else if (r_rp >= r_pe) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_H0;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_HDR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(haddr_i);
                wr_data = hbyte;
                if (r_hcnt == HCNT_END) begin
                    n_state = S_IDLE;
                end else begin
                    n_hcnt = r_hcnt + HCW'(1);
                end
            end
            S_H0: begin
                n_mlen = {4'd0, r_rd_data};
                if (HEADER_BYTES > 1) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(rp_p1);
                    n_state = S_H1;
                end else begin
                    n_state = S_HD;
                end
            end
            S_H1: begin
                n_mlen[LEN_W-1:8] = r_rd_data[3:0];
                n_state = S_HD;
            end
            S_HD: begin
                if (r_mlen != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(rp_h);
                    n_rp    = rp_h;
                    n_first = 1'b1;
                    n_state = S_PL;
                end else if (can_out) begin
                    // zero-length message: one pop marks both ends
                    n_out_valid            = 1'b1;
                    n_out                  = '0;
                    n_out.first_of_message = 1'b1;
                    n_out.last_of_message  = 1'b1;
                    n_rp                   = rp_h;
                    if (rp_h >= r_pe) begin
                        n_rp = '0;
                        n_pe = r_se;
                        n_se = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_PL: begin
                if (can_out) begin
                    n_out_valid            = 1'b1;
                    n_out                  = '0;
                    n_out.out_byte         = r_rd_data;
                    n_out.byte_valid       = 1'b1;
                    n_out.first_of_message = r_first;
                    n_rp                   = rp_p1;
                    n_btp                  = btp_new;
                    if (btp_new == '0) begin
                        n_out.last_of_message = 1'b1;
                        n_inside              = 1'b0;
                        // primary drained: secondary takes its place
                        if (rp_p1 >= r_pe) begin
                            n_rp = '0;
                            n_pe = r_se;
                            n_se = '0;
                        end
                    end else begin
                        n_inside = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_pe        <= '0;
            r_se        <= '0;
            r_fp        <= '0;
            r_btf       <= '0;
            r_btp       <= '0;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_pe        <= n_pe;
            r_se        <= n_se;
            r_fp        <= n_fp;
            r_btf       <= n_btf;
            r_btp       <= n_btp;
            r_inside    <= n_inside;
            r_out_valid <= n_out_valid;
        end
        r_mlen  <= n_mlen;
        r_first <= n_first;
        r_hcnt  <= n_hcnt;
        r_hlen  <= n_hlen;
        r_haddr <= n_haddr;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// File: rtl/bip_buffer_message_queue.sv
// top level of the bip buffer message queue
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------
//  request  | i_in_valid/o_in_stall | i_in  (t_in_item)
//  result   | o_out_valid/i_out_stall | o_out (t_out_item)
//
// one result per request, in request order; each request is registered in a two-entry queue
// a fill writes its payload byte to the store; a send writes its header one byte per store write
// a pop inside a message reads its byte through the registered store read
// opening pop: header read byte by byte, at most two bytes (S_H0, S_H1), then S_HD, S_PL
// reset is synchronous and clears pointers and counts; the byte store is not cleared
// a stalled result holds the back end; the front keeps taking requests until its queue fills
`default_nettype none
module bip_buffer_message_queue #(
    parameter int BUFFER_BYTES = bbmq_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES = bbmq_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire bbmq_pkg::t_in_item  i_in,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output bbmq_pkg::t_out_item      o_out
);
    import bbmq_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_deq;

    bbmq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_deq   (cmd_deq)
    );

    bbmq_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_deq   (cmd_deq),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: rtl/bbmq_checker.sv
// port-level checks for the bip buffer message queue, bound to the top level
`default_nettype none
module bbmq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire bbmq_pkg::t_out_item o_out
);
    import bbmq_pkg::*;

    // no result can be pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // an answer with any status but OK carries no pop markers
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_OK) |->
            !o_out.byte_valid && !o_out.first_of_message && !o_out.last_of_message
            && (o_out.out_byte == '0))
        else $error("failed request carries pop data");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.byte_valid |-> (o_out.out_byte == '0))
        else $error("out_byte set without byte_valid");

endmodule

bind bip_buffer_message_queue bbmq_checker u_bbmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
`default_nettype wire

// File: tb/bip_buffer_message_queue_tb.sv
// testbench for the bip buffer message queue: scoreboard against a behavioral queue model
`timescale 1ns / 100ps
`default_nettype none
module bip_buffer_message_queue_tb;
    import bbmq_pkg::*;

    localparam int BUF_BYTES = 4096;
    localparam int HDR_BYTES = 2;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in;
    logic      o_in_stall;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    bip_buffer_message_queue DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in(i_in), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    // queue model state
    logic [7:0]  mem [BUF_BYTES];
    int unsigned rd_ptr, prim_end, sec_end, wr_ptr, fill_left, pop_left;
    logic        in_msg;

    t_in_item  pending_reqs[$];
    t_out_item expected_results[$];
    int        error_count;
    int        popped_bytes, sent_msgs, refused_sends, accepted_reqs;
    bit        hold_out;
    bit        sender_pause;
    bit        paused_once;
    bit        stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
    endtask

    function automatic void drain_region();
        if (rd_ptr >= prim_end) begin
            rd_ptr = 0;
            prim_end = sec_end;
            sec_end = 0;
        end
    endfunction

    function automatic void reserve(input int unsigned start, input int unsigned len);
        for (int i = 0; i < HDR_BYTES; i++) mem[(start + i) % BUF_BYTES] = 8'(len >> (8 * i));
        wr_ptr = start + HDR_BYTES;
        fill_left = len;
    endfunction

    function automatic logic [1:0] try_send(input int unsigned len);
        int unsigned total;
        total = HDR_BYTES + len;
        if (fill_left != 0) return ST_BUSY;
        if (sec_end > 0) begin
            if (rd_ptr >= sec_end && rd_ptr - sec_end >= total) begin
                reserve(sec_end, len);
                sec_end += total;
                return ST_OK;
            end
            return ST_NO_ROOM;
        end
        if (prim_end <= BUF_BYTES && BUF_BYTES - prim_end >= total) begin
            reserve(prim_end, len);
            prim_end += total;
            return ST_OK;
        end
        if (rd_ptr >= sec_end && rd_ptr - sec_end >= total) begin
            reserve(sec_end, len);
            sec_end += total;
            return ST_OK;
        end
        return ST_NO_ROOM;
    endfunction

    function automatic t_out_item predict_queue(input t_in_item req);
        t_out_item   res;
        int unsigned mlen;
        res = '0;
        case (req.req_type)
            REQ_SEND: begin
                res.status = try_send(req.msg_length);
                if (res.status == ST_OK) sent_msgs++;
                if (res.status == ST_NO_ROOM) refused_sends++;
            end
            REQ_FILL: begin
                if (fill_left == 0) res.status = ST_BUSY;
                else begin
                    mem[wr_ptr % BUF_BYTES] = req.data_byte;
                    wr_ptr++;
                    fill_left--;
                end
            end
            REQ_POP: begin
                if (fill_left != 0) res.status = ST_BUSY;
                else if (in_msg) begin
                    res.out_byte = mem[rd_ptr % BUF_BYTES];
                    rd_ptr++;
                    pop_left = (pop_left - 1) & 12'hFFF;
                    res.byte_valid = 1'b1;
                    if (pop_left == 0) begin
                        res.last_of_message = 1'b1;
                        in_msg = 1'b0;
                        drain_region();
                    end
                end else if (rd_ptr >= prim_end) res.status = ST_EMPTY;
                else begin
                    mlen = 0;
                    for (int i = 0; i < HDR_BYTES; i++)
                        mlen |= int'(mem[(rd_ptr + i) % BUF_BYTES]) << (8 * i);
                    mlen &= 12'hFFF;
                    rd_ptr += HDR_BYTES;
                    res.first_of_message = 1'b1;
                    if (mlen == 0) begin
                        res.last_of_message = 1'b1;
                        drain_region();
                    end else begin
                        res.out_byte = mem[rd_ptr % BUF_BYTES];
                        rd_ptr++;
                        res.byte_valid = 1'b1;
                        pop_left = mlen - 1;
                        if (pop_left == 0) begin
                            res.last_of_message = 1'b1;
                            drain_region();
                        end else in_msg = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (res.byte_valid) popped_bytes++;
        return res;
    endfunction

    function automatic t_in_item make_req(input logic [1:0] kind, input int len, input int d);
        t_in_item r;
        r.req_type = kind;
        r.msg_length = 12'(len);
        r.data_byte = 8'(d);
        return r;
    endfunction

    task automatic add_message(input int len);
        pending_reqs.push_back(make_req(REQ_SEND, len, $urandom));
        for (int i = 0; i < len; i++)
            pending_reqs.push_back(make_req(REQ_FILL, $urandom, $urandom));
    endtask

    task automatic add_pops(input int n);
        for (int i = 0; i < n; i++) pending_reqs.push_back(make_req(REQ_POP, $urandom, $urandom));
    endtask

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // request driver
    int gap_cnt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_cnt <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                expected_results.push_back(predict_queue(i_in));
                accepted_reqs++;
            end
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !sender_pause) begin
                i_in <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                gap_cnt <= short_or_long_gap();
            end else i_in_valid <= 1'b0;
        end
    end

    // result monitor with random stalls
    int stall_cnt;
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) report_mismatch("unexpected result", 1, 0);
                else begin
                    exp_res = expected_results.pop_front();
                    if (o_out.status != exp_res.status)
                        report_mismatch("status", o_out.status, exp_res.status);
                    if (o_out.out_byte != exp_res.out_byte)
                        report_mismatch("out_byte", o_out.out_byte, exp_res.out_byte);
                    if (o_out.byte_valid != exp_res.byte_valid)
                        report_mismatch("byte_valid", o_out.byte_valid, exp_res.byte_valid);
                    if (o_out.first_of_message != exp_res.first_of_message)
                        report_mismatch("first", o_out.first_of_message,
                                        exp_res.first_of_message);
                    if (o_out.last_of_message != exp_res.last_of_message)
                        report_mismatch("last", o_out.last_of_message,
                                        exp_res.last_of_message);
                end
            end
            if (hold_out) i_out_stall <= 1'b1;
            else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                i_out_stall <= 1'b1;
            end else begin
                stall_cnt <= short_or_long_gap();
                i_out_stall <= 1'b0;
            end
        end
    end

    // long receiver hold-off while the sender keeps going
    initial begin
        hold_out = 1'b0;
        wait (accepted_reqs > 300);
        hold_out = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_out = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("bip_buffer_message_queue_tb: FAIL");
        $finish;
    end

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !i_in_valid && expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int kind, len;
        error_count = 0;
        popped_bytes = 0; sent_msgs = 0; refused_sends = 0; accepted_reqs = 0;
        rd_ptr = 0; prim_end = 0; sec_end = 0; wr_ptr = 0;
        fill_left = 0; pop_left = 0; in_msg = 1'b0;
        sender_pause = 1'b1;
        paused_once = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, stray byte, unused type, too long, zero length, busy cases
        pending_reqs.push_back(make_req(REQ_POP, 0, 0));
        pending_reqs.push_back(make_req(REQ_FILL, 0, 8'hFF));
        pending_reqs.push_back(make_req(2'd3, 12'hFFF, 8'hFF));
        pending_reqs.push_back(make_req(REQ_SEND, 4095, 0));
        pending_reqs.push_back(make_req(REQ_SEND, 4095, 0));
        add_message(0);
        add_pops(2);
        pending_reqs.push_back(make_req(REQ_SEND, 3, 0));
        pending_reqs.push_back(make_req(REQ_SEND, 1, 0));
        pending_reqs.push_back(make_req(REQ_POP, 0, 0));
        pending_reqs.push_back(make_req(REQ_FILL, 0, 8'h00));
        pending_reqs.push_back(make_req(REQ_FILL, 0, 8'hAA));
        pending_reqs.push_back(make_req(REQ_FILL, 0, 8'h55));
        add_message(1);
        add_pops(5);
        sender_pause = 1'b0;
        wait_idle();

        // random: mostly well-formed sends and pops, some noise
        while (accepted_reqs + pending_reqs.size() < 940) begin
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                len = ($urandom_range(0, 30) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(0, 12);
                add_message(len);
            end else if (kind < 16) add_pops($urandom_range(1, 10));
            else if (kind < 18)
                pending_reqs.push_back(make_req(2'($urandom_range(1, 3)), $urandom, $urandom));
            else pending_reqs.push_back(make_req(REQ_SEND,
                     ($urandom_range(0, 1) == 0) ? 4095 : $urandom_range(0, 3), 0));
            if (pending_reqs.size() > 40) wait (pending_reqs.size() < 10);
            if (accepted_reqs > 700 && !paused_once) begin
                // sender stops until all results are back
                paused_once = 1'b1;
                sender_pause = 1'b1;
                wait (!i_in_valid && expected_results.size() == 0);
                sender_pause = 1'b0;
            end
        end
        add_pops(200);
        wait_idle();
        $display("covered %0d requests: %0d messages sent, %0d refused, %0d bytes popped",
                 accepted_reqs, sent_msgs, refused_sends, popped_bytes);
        if (error_count == 0) $display("bip_buffer_message_queue_tb: PASS");
        else $display("bip_buffer_message_queue_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
